[rtl/bct_pkg.sv]
// ============================================================================
// bct_pkg
// Shared constants, types and codes of the birthday collision table.
// ============================================================================
`default_nettype none

package bct_pkg;

    // Table geometry and hash word layout.
    localparam int TABLE_BITS   = 20;
    localparam int SEARCH_BITS  = 50;
    localparam int BUCKET_COUNT = 1 << TABLE_BITS;
    localparam int HASH_W       = 64;
    localparam int INDEX_W      = 20;
    localparam int ENTRY_W      = 32;

    // The birthday is the top SEARCH_BITS bits of the hash word.
    localparam int BDAY_SHIFT   = HASH_W - SEARCH_BITS;
    // The check key is taken from the birthday shifted down by 18.
    localparam int KEY_SHIFT    = BDAY_SHIFT + 18;

    localparam logic [ENTRY_W-1:0] KEY_MASK   = {ENTRY_W{1'b1}} << TABLE_BITS;
    localparam logic [ENTRY_W-1:0] INDEX_MASK =
        ENTRY_W'((64'd1 << INDEX_W) - 64'd1);

    // Request kinds.
    localparam logic FUNC_CLEAR  = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // Command queue.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                  clr;
        logic [TABLE_BITS-1:0] slot;
        logic [ENTRY_W-1:0]    key;
        logic [INDEX_W-1:0]    idx;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/bct_ram.sv]
// ============================================================================
// bct_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ============================================================================
`default_nettype none

module bct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read returns the contents before a write to the same address this cycle.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bct_front.sv]
// ============================================================================
// bct_front
// Accepts requests, classifies them and derives bucket, check key and index.
// ============================================================================
`default_nettype none

module bct_front (
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_func,
    input  wire logic [bct_pkg::HASH_W-1:0]     i_hash_word,
    input  wire logic [bct_pkg::INDEX_W-1:0]    i_nonce_index,
    input  wire logic                           i_init_busy,
    input  wire logic                           i_q_ready,
    output logic                                o_push,
    output bct_pkg::t_cmd                       o_cmd
);

    logic [bct_pkg::HASH_W-1:0] bday;
    logic [bct_pkg::HASH_W-1:0] key_full;

    assign bday     = i_hash_word >> bct_pkg::BDAY_SHIFT;
    assign key_full = i_hash_word >> bct_pkg::KEY_SHIFT;

    // Requests wait while the table is being cleared after reset.
    assign o_ready = i_q_ready && !i_init_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd.clr  = (i_func == bct_pkg::FUNC_CLEAR);
        o_cmd.slot = bday[bct_pkg::TABLE_BITS-1:0];
        o_cmd.key  = key_full[bct_pkg::ENTRY_W-1:0] & bct_pkg::KEY_MASK;
        o_cmd.idx  = i_nonce_index;
    end

endmodule

`default_nettype wire

[rtl/bct_queue.sv]
// ============================================================================
// bct_queue
// Short command queue between the request front and the table back end.
// ============================================================================
`default_nettype none

module bct_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bct_pkg::t_cmd i_cmd,
    output logic               o_ready,
    input  wire logic          i_pop,
    output logic               o_valid,
    output bct_pkg::t_cmd      o_cmd
);

    bct_pkg::t_cmd                 r_buf [bct_pkg::QDEPTH];
    logic [bct_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [bct_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [bct_pkg::QCNT_W-1:0]    r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_ready = (r_count != bct_pkg::QCNT_W'(bct_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_buf[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/bct_back.sv]
// ============================================================================
// bct_back
// Table back end: bucket lookup, key compare, entry update and clear sweep.
// ============================================================================
`default_nettype none

module bct_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire bct_pkg::t_cmd                i_q_cmd,
    output logic                              o_q_pop,
    output logic                              o_init_busy,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_candidate,
    output logic [bct_pkg::INDEX_W-1:0]       o_earlier_index,
    output logic [bct_pkg::INDEX_W-1:0]       o_later_index
);

    // Clear sweep state.
    logic                              r_sweep_busy;
    logic                              r_init_busy;
    logic [bct_pkg::TABLE_BITS-1:0]    r_sweep_addr;

    // Compare stage: one insert whose bucket read is in flight.
    logic                              r_b_valid;
    logic [bct_pkg::TABLE_BITS-1:0]    r_b_slot;
    logic [bct_pkg::ENTRY_W-1:0]       r_b_key;
    logic [bct_pkg::INDEX_W-1:0]       r_b_idx;
    logic                              r_fwd_hit;
    logic [bct_pkg::ENTRY_W-1:0]       r_fwd_data;

    // Result register.
    logic                              r_out_valid;
    logic                              r_out_cand;
    logic [bct_pkg::INDEX_W-1:0]       r_out_earlier;
    logic [bct_pkg::INDEX_W-1:0]       r_out_later;

    logic                              out_free;
    logic                              b_done;
    logic                              ins_pop;
    logic                              clr_pop;
    logic                              ram_we;
    logic [bct_pkg::TABLE_BITS-1:0]    ram_waddr;
    logic [bct_pkg::ENTRY_W-1:0]       ram_wdata;
    logic [bct_pkg::ENTRY_W-1:0]       ram_rdata;
    logic [bct_pkg::ENTRY_W-1:0]       old_entry;
    logic [bct_pkg::ENTRY_W-1:0]       new_entry;
    logic [bct_pkg::ENTRY_W-1:0]       old_index;
    logic                              hit;

    assign out_free = !r_out_valid || i_ready;
    assign b_done   = r_b_valid && out_free;

    // An insert enters the compare stage as soon as the stage frees up.
    // A clear waits until the stage is empty and the result register is free.
    assign ins_pop = i_q_valid && !r_sweep_busy && !i_q_cmd.clr
                     && (!r_b_valid || b_done);
    assign clr_pop = i_q_valid && !r_sweep_busy && i_q_cmd.clr
                     && !r_b_valid && out_free;
    assign o_q_pop = ins_pop || clr_pop;

    // A write landing in the same cycle as the read is forwarded.
    assign old_entry = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign hit       = (old_entry != '0)
                       && ((old_entry & bct_pkg::KEY_MASK) == r_b_key);
    assign old_index = old_entry & ~bct_pkg::KEY_MASK & bct_pkg::INDEX_MASK;
    assign new_entry = bct_pkg::ENTRY_W'(r_b_idx) | r_b_key;

    always_comb begin
        if (r_sweep_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = b_done;
            ram_waddr = r_b_slot;
            ram_wdata = new_entry;
        end
    end

    bct_ram #(
        .WIDTH (bct_pkg::ENTRY_W),
        .DEPTH (bct_pkg::BUCKET_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ins_pop),
        .i_raddr (i_q_cmd.slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_busy <= 1'b1;
            r_init_busy  <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_sweep_busy) begin
            r_sweep_addr <= r_sweep_addr + 1'b1;
            if (r_sweep_addr == {bct_pkg::TABLE_BITS{1'b1}}) begin
                r_sweep_busy <= 1'b0;
                r_init_busy  <= 1'b0;
            end
        end else if (clr_pop) begin
            r_sweep_busy <= 1'b1;
            r_sweep_addr <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ins_pop) begin
            r_b_valid <= 1'b1;
        end else if (b_done) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins_pop) begin
            r_b_slot   <= i_q_cmd.slot;
            r_b_key    <= i_q_cmd.key;
            r_b_idx    <= i_q_cmd.idx;
            r_fwd_hit  <= ram_we && (ram_waddr == i_q_cmd.slot);
            r_fwd_data <= ram_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_done || clr_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_done) begin
            r_out_cand    <= hit;
            r_out_earlier <= hit ? old_index[bct_pkg::INDEX_W-1:0] : '0;
            r_out_later   <= r_b_idx;
        end else if (clr_pop) begin
            r_out_cand    <= 1'b0;
            r_out_earlier <= '0;
            r_out_later   <= '0;
        end
    end

    assign o_init_busy     = r_init_busy;
    assign o_valid         = r_out_valid;
    assign o_candidate     = r_out_cand;
    assign o_earlier_index = r_out_earlier;
    assign o_later_index   = r_out_later;

    // The compare stage is always empty while the table is swept.
    a_sweep_no_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep_busy |-> !r_b_valid)
        else $error("insert in flight during clear sweep");

    // Without a candidate the earlier index reads as zero.
    a_no_cand_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_cand) |-> (r_out_earlier == '0))
        else $error("earlier index set without candidate");

    // A clear starts a sweep from the first bucket.
    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_pop |=> (r_sweep_busy && (r_sweep_addr == '0)))
        else $error("clear did not start a sweep");

    // Only one of insert and clear leaves the queue in a cycle.
    a_single_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ins_pop && clr_pop))
        else $error("insert and clear popped together");

endmodule

`default_nettype wire

[rtl/birthday_collision_table.sv]
// ============================================================================
// birthday_collision_table
// Birthday collision table: bucket lookup by hash birthday, key match report.
// ============================================================================
// Requests arrive on the s_axis channel: tuser carries the kind (clear or
// insert), tdata the hash word and its nonce index. Every request gives one
// result on the m_axis channel: tuser is the candidate flag, tdata holds the
// earlier (stored) index and the later (current) index.
// An accepted request enters a four-deep command queue. An insert leaves the
// queue and reads its bucket; once the bucket data is registered, it compares
// the key, rewrites the bucket and loads the result register. Inserts sustain
// one per cycle when nothing stalls; the single read and single write port
// of the bucket RAM set that.
// A clear waits for earlier inserts to drain, posts its all-zero result and
// then zeroes the table one bucket a cycle, across all 2^TABLE_BITS buckets;
// requests still queue up meanwhile.
// After reset the same sweep runs and s_axis_tready stays low until it ends.
// When the receiver stalls, the result register holds, the compare stage
// holds its bucket data, and the queue fills before s_axis_tready drops.
// ============================================================================
`default_nettype none

module birthday_collision_table (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [87:0]  s_axis_tdata,  // [63:0] hash_word, [83:64] nonce_index
    input  wire logic         s_axis_tuser,  // [0] func
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata,  // [19:0] earlier_index, [39:20] later_index
    output logic              m_axis_tuser   // [0] candidate
);

    bct_pkg::t_cmd                front_cmd;
    bct_pkg::t_cmd                q_cmd;
    logic                         front_push;
    logic                         q_ready;
    logic                         q_valid;
    logic                         q_pop;
    logic                         init_busy;
    logic [bct_pkg::INDEX_W-1:0]  earlier_index;
    logic [bct_pkg::INDEX_W-1:0]  later_index;

    bct_front u_front (
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_func        (s_axis_tuser),
        .i_hash_word   (s_axis_tdata[63:0]),
        .i_nonce_index (s_axis_tdata[83:64]),
        .i_init_busy   (init_busy),
        .i_q_ready     (q_ready),
        .o_push        (front_push),
        .o_cmd         (front_cmd)
    );

    bct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    bct_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .o_init_busy     (init_busy),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_candidate     (m_axis_tuser),
        .o_earlier_index (earlier_index),
        .o_later_index   (later_index)
    );

    assign m_axis_tdata = {later_index, earlier_index};

endmodule

`default_nettype wire
